[rtl/core/polyline_ordinate_range_clipper_top_assert.svh]
// Assertion macros for the polyline ordinate range clipper.
// Used by polyline_ordinate_range_clipper_top; expects clk and rst_n in scope.
`ifndef POLYLINE_ORDINATE_RANGE_CLIPPER_TOP_ASSERT_SVH
`define POLYLINE_ORDINATE_RANGE_CLIPPER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PORC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("porc: invariant violated");
`define PORC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("porc: sequence violated");
`else
`define PORC_ASSERT_ALWAYS(lbl, cond)
`define PORC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/porc_pkg.sv]
// Shared types and constants for the polyline ordinate range clipper.
// No dependencies; used by the channel interfaces and the top level.
package porc_pkg;

  localparam int DATA_W    = 32;
  localparam int PROP_W    = 25;
  localparam int DIV_STEPS = 24;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int NORD      = 4;

  localparam logic [PROP_W-1:0] ONE_Q24 = PROP_W'(1) << DIV_STEPS;

  localparam logic [1:0] REG_CLIP_LOW  = 2'd0;
  localparam logic [1:0] REG_CLIP_HIGH = 2'd1;
  localparam logic [1:0] REG_ORD_SEL   = 2'd2;
  localparam logic [1:0] REG_DIMS      = 2'd3;

  localparam logic [1:0] IM_NONE  = 2'd0;
  localparam logic [1:0] IM_INNER = 2'd1;
  localparam logic [1:0] IM_BOUND = 2'd2;

  typedef logic signed [DATA_W-1:0] coord_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_VERTEX,
    K_FWD,
    K_REV,
    K_CLOSE
  } kind_t;

endpackage

[rtl/core/porc_in_if.sv]
// Vertex input channel: valid/ready handshake with one polyline vertex.
// Depends on porc_pkg for the coordinate type.
interface porc_in_if import porc_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t vx;
  coord_t vy;
  coord_t vz;
  coord_t vm;
  logic   line_end;

  modport source(output valid, vx, vy, vz, vm, line_end, input ready);
  modport sink(input valid, vx, vy, vz, vm, line_end, output ready);
endinterface

[rtl/core/porc_out_if.sv]
// Result channel: valid/ready handshake with one clipped point or close marker.
// Depends on porc_pkg for the coordinate type.
interface porc_out_if import porc_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t ox;
  coord_t oy;
  coord_t oz;
  coord_t om;
  logic   has_point;
  logic   part_end;
  logic   run_last;

  modport source(output valid, ox, oy, oz, om, has_point, part_end, run_last, input ready);
  modport sink(input valid, ox, oy, oz, om, has_point, part_end, run_last, output ready);
endinterface

[rtl/core/polyline_ordinate_range_clipper_top.sv]
// Polyline ordinate range clipper: one vertex in, up to two results out.
// Depends on porc_pkg, porc_in_if, porc_out_if and the assertion header.
//
// Clips a streamed polyline to the band [min(low,high), max(low,high)] on the
// selected ordinate. A vertex is taken only while the block is idle, and the
// block stays busy until every result of that vertex has been transferred.
// A vertex with no result frees the input at once. A vertex that needs no
// boundary point passes through the load and emit states only. Each
// boundary point runs through one shared unit: a 24-step restoring divider
// for the Q1.24 proportion followed by one multiplier used in turn for the
// four ordinates, in the steps load, divide, multiply and accumulate per
// ordinate, and emit. The divide is skipped when the proportion is known to
// be 0 (zero difference on the selected ordinate) or 1 (target at or past
// the far vertex). Output stalls hold the block busy in the emit state.
// The divider produces one quotient bit per cycle.
// Configuration must be written only while the block is idle.
`include "polyline_ordinate_range_clipper_top_assert.svh"

module polyline_ordinate_range_clipper_top import porc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  porc_in_if.sink      in_chan,
  porc_out_if.source   out_chan,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_data
);

  // configuration
  coord_t     clip_low_r, clip_high_r;
  logic [1:0] ord_sel_r;
  logic [2:0] dims_r;

  // line state
  coord_t     prv_r [NORD];
  coord_t     cur_r [NORD];
  coord_t     res_r [NORD];
  coord_t     prev_key_r;
  logic [1:0] im_r;
  logic       po_r;
  logic       at_start_r;

  // sequencer
  state_t     state_r, state_nxt;
  logic       slot_r;
  logic [1:0] n_r;
  kind_t      kind0_r, kind1_r;
  logic       hi0_r, hi1_r;
  logic       pe_r;
  logic [DATA_W-1:0] rem_r, den_r;
  logic [DIV_STEPS-2:0] quo_r;
  logic [PROP_W-1:0] prop_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        ord_r;
  logic [DATA_W-1:0] t_r;
  logic              neg_r;

  logic in_fire, out_fire;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  // range bounds and incoming key
  coord_t lo, hi, key, q;
  coord_t vin [NORD];
  logic   bad, in_rng, le, first;

  assign lo  = (clip_low_r < clip_high_r) ? clip_low_r : clip_high_r;
  assign hi  = (clip_low_r < clip_high_r) ? clip_high_r : clip_low_r;
  assign vin[0] = in_chan.vx;
  assign vin[1] = in_chan.vy;
  assign vin[2] = in_chan.vz;
  assign vin[3] = in_chan.vm;
  assign key = vin[ord_sel_r];
  assign q   = prev_key_r;
  assign le  = in_chan.line_end;
  assign first  = at_start_r;
  assign bad    = {1'b0, ord_sel_r} >= dims_r;
  assign in_rng = (key >= lo) && (key <= hi);

  // plan the results of the incoming vertex
  logic [1:0] p_n, p_im;
  kind_t      p_k0, p_k1;
  logic       p_h0, p_h1, p_pe, p_po, po_cur;

  always_comb begin
    p_n = 2'd0; p_k0 = K_VERTEX; p_k1 = K_VERTEX; p_h0 = 1'b0; p_h1 = 1'b0;
    p_pe = 1'b0; p_im = IM_NONE; p_po = 1'b0; po_cur = po_r;
    if (bad) begin
      p_n = 2'd0;
    end else if (in_rng) begin
      if (im_r == IM_NONE && !first &&
          ((key > lo && key < hi) || (key == lo && q > hi) || (key == hi && q < lo))) begin
        p_n = 2'd2; p_k0 = K_FWD; p_h0 = (q > hi); p_k1 = K_VERTEX;
      end else begin
        p_n = 2'd1; p_k0 = K_VERTEX;
      end
      p_im = (key == lo || key == hi) ? IM_BOUND : IM_INNER;
      p_po = 1'b1;
      if (le) begin
        p_pe = 1'b1; p_po = 1'b0; p_im = IM_NONE;
      end
    end else begin
      if (im_r == IM_INNER) begin
        p_n = 2'd1; p_k0 = K_FWD; p_h0 = (key > hi);
      end else if (im_r == IM_BOUND) begin
        if (lo != hi && ((q == lo && key > lo) || (q == hi && key < hi))) begin
          p_n = 2'd1; p_k0 = K_FWD; p_h0 = (key > hi);
        end
      end else if (!first && q < lo && key > hi) begin
        p_n = 2'd2; p_k0 = K_REV; p_h0 = 1'b0; p_k1 = K_REV; p_h1 = 1'b1; po_cur = 1'b1;
      end else if (!first && q > hi && key < lo) begin
        p_n = 2'd2; p_k0 = K_REV; p_h0 = 1'b1; p_k1 = K_REV; p_h1 = 1'b0; po_cur = 1'b1;
      end
      // close the part: mark the last point, or add a close-only marker
      if (po_cur) begin
        p_pe = 1'b1;
        if (p_n == 2'd0) begin
          p_n = 2'd1; p_k0 = K_CLOSE;
        end
      end
    end
  end

  // operands of the current slot
  kind_t  kind;
  logic   tgt_hi, rev, last_slot;
  coord_t a_pt [NORD];
  coord_t b_pt [NORD];
  coord_t tgt, ak, bk;
  logic signed [DATA_W:0] num_s, den_s, d_s;
  logic [DATA_W-1:0] num_m, den_m, d_m, t_signed;
  logic [DATA_W:0]   rem2;
  logic              rem_ge;
  logic [DATA_W+PROP_W-1:0] prod;

  assign kind      = slot_r ? kind1_r : kind0_r;
  assign tgt_hi    = slot_r ? hi1_r : hi0_r;
  assign rev       = (kind == K_REV);
  assign last_slot = ({1'b0, slot_r} == n_r - 2'd1);

  always_comb begin
    for (int i = 0; i < NORD; i++) begin
      a_pt[i] = rev ? cur_r[i] : prv_r[i];
      b_pt[i] = rev ? prv_r[i] : cur_r[i];
    end
  end

  assign tgt   = tgt_hi ? hi : lo;
  assign ak    = a_pt[ord_sel_r];
  assign bk    = b_pt[ord_sel_r];
  assign num_s = {tgt[DATA_W-1], tgt} - {ak[DATA_W-1], ak};
  assign den_s = {bk[DATA_W-1], bk} - {ak[DATA_W-1], ak};
  assign num_m = num_s[DATA_W] ? DATA_W'(-num_s) : num_s[DATA_W-1:0];
  assign den_m = den_s[DATA_W] ? DATA_W'(-den_s) : den_s[DATA_W-1:0];

  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den_r};

  assign d_s  = {b_pt[ord_r][DATA_W-1], b_pt[ord_r]} - {a_pt[ord_r][DATA_W-1], a_pt[ord_r]};
  assign d_m  = d_s[DATA_W] ? DATA_W'(-d_s) : d_s[DATA_W-1:0];
  assign prod = d_m * prop_r;
  assign t_signed = neg_r ? (~t_r + DATA_W'(1)) : t_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && p_n != 2'd0) state_nxt = S_LOAD;
      S_LOAD: begin
        if (kind == K_VERTEX || kind == K_CLOSE) state_nxt = S_EMIT;
        else if (den_m == '0 || num_m >= den_m) state_nxt = S_MUL;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (ord_r == 2'(NORD - 1)) ? S_EMIT : S_MUL;
      S_EMIT: if (out_fire) state_nxt = last_slot ? S_IDLE : S_LOAD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_low_r <= '0; clip_high_r <= '0; ord_sel_r <= '0; dims_r <= 3'd4;
      prev_key_r <= '0; im_r <= IM_NONE; po_r <= 1'b0; at_start_r <= 1'b1;
      for (int i = 0; i < NORD; i++) prv_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CLIP_LOW:  clip_low_r  <= cfg_data;
          REG_CLIP_HIGH: clip_high_r <= cfg_data;
          REG_ORD_SEL:   ord_sel_r   <= cfg_data[1:0];
          REG_DIMS:      dims_r      <= cfg_data[2:0];
          default:       ;
        endcase
      end
      if (in_fire) begin
        prev_key_r <= key;
        im_r       <= p_im;
        po_r       <= p_po;
        at_start_r <= le;
        // with no results the vertex becomes the previous one at once
        if (p_n == 2'd0) begin
          for (int i = 0; i < NORD; i++) prv_r[i] <= vin[i];
        end
      end
      if (state_r == S_EMIT && out_fire && last_slot) begin
        for (int i = 0; i < NORD; i++) prv_r[i] <= cur_r[i];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 1'b0; n_r <= '0; cnt_r <= '0; ord_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) begin
          for (int i = 0; i < NORD; i++) cur_r[i] <= vin[i];
          slot_r <= 1'b0; n_r <= p_n;
          kind0_r <= p_k0; kind1_r <= p_k1; hi0_r <= p_h0; hi1_r <= p_h1; pe_r <= p_pe;
        end
        S_LOAD: begin
          ord_r <= '0;
          cnt_r <= '0;
          if (kind == K_VERTEX) begin
            for (int i = 0; i < NORD; i++) res_r[i] <= cur_r[i];
          end else if (kind == K_CLOSE) begin
            for (int i = 0; i < NORD; i++) res_r[i] <= '0;
          end else if (den_m == '0) begin
            prop_r <= '0;
          end else if (num_m >= den_m) begin
            prop_r <= ONE_Q24;
          end else begin
            rem_r <= num_m; den_r <= den_m; quo_r <= '0;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          rem_r <= rem_ge ? DATA_W'(rem2 - {1'b0, den_r}) : rem2[DATA_W-1:0];
          quo_r <= {quo_r[DIV_STEPS-3:0], rem_ge};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) prop_r <= {1'b0, quo_r, rem_ge};
        end
        S_MUL: begin
          t_r   <= prod[DIV_STEPS+DATA_W-1:DIV_STEPS];
          neg_r <= d_s[DATA_W];
        end
        S_ACC: begin
          res_r[ord_r] <= a_pt[ord_r] + t_signed;
          ord_r <= ord_r + 2'd1;
        end
        S_EMIT: if (out_fire && !last_slot) slot_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // ports
  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = (state_r == S_EMIT);
  assign out_chan.has_point = (kind != K_CLOSE);
  assign out_chan.part_end  = last_slot && pe_r;
  assign out_chan.run_last  = last_slot;
  assign out_chan.ox = (out_chan.has_point && dims_r > 3'd0) ? res_r[0] : '0;
  assign out_chan.oy = (out_chan.has_point && dims_r > 3'd1) ? res_r[1] : '0;
  assign out_chan.oz = (out_chan.has_point && dims_r > 3'd2) ? res_r[2] : '0;
  assign out_chan.om = (out_chan.has_point && dims_r > 3'd3) ? res_r[3] : '0;

  `PORC_ASSERT_ALWAYS(a_no_overlap, !(in_chan.ready && out_chan.valid))
  `PORC_ASSERT_NEXT(a_bad_no_result, in_fire && bad, state_r == S_IDLE)
  `PORC_ASSERT_NEXT(a_last_frees, out_fire && out_chan.run_last, in_chan.ready)
  `PORC_ASSERT_ALWAYS(a_close_ends, out_chan.valid && !out_chan.has_point |-> out_chan.part_end)

endmodule

[dv/porc_tb_if.sv]
`timescale 1ns / 1ps
// Testbench-side note: the block's channel interfaces come from rtl/core.
// This file holds the result descriptor type used by the checker.
// Depends on porc_pkg.
package porc_tb_pkg;
  import porc_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t m;
    logic   has_point;
    logic   part_end;
    logic   run_last;
  } clip_result_t;
endpackage

[dv/porc_checker.sv]
`timescale 1ns / 1ps
// Checker for the polyline clipper: watches both channels and the register port,
// predicts the clipped points and compares them in order.
// Depends on porc_pkg, porc_tb_pkg and the channel interfaces.
module porc_checker import porc_pkg::*, porc_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  porc_in_if          in_chan,
  porc_out_if         out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  coord_t     band_a, band_b;
  logic [1:0] axis_sel;
  logic [2:0] dims;
  coord_t     last_pt [4];
  coord_t     last_key;
  logic [1:0] track;
  logic       part_live, line_fresh;
  clip_result_t results_due [$];
  clip_result_t staged [$];

  assign pending = results_due.size();

  function automatic logic [63:0] magnitude(logic signed [63:0] d);
    return d < 0 ? -d : d;
  endfunction

  function automatic void interpolate(input coord_t a [4], input coord_t b [4],
                                      input coord_t target, output coord_t r [4]);
    logic signed [63:0] ka, kb, d;
    logic [63:0] num, den, prop, t;
    ka = a[axis_sel];
    kb = b[axis_sel];
    num = magnitude(64'(target) - ka);
    den = magnitude(kb - ka);
    prop = den != 0 ? (num << 24) / den : 0;
    if (prop > 64'(ONE_Q24)) prop = 64'(ONE_Q24);
    for (int i = 0; i < 4; i++) begin
      d = 64'(b[i]) - 64'(a[i]);
      t = (magnitude(d) * prop) >> 24;
      r[i] = coord_t'(d < 0 ? 64'(a[i]) - t : 64'(a[i]) + t);
    end
  endfunction

  function automatic void stage_point(input coord_t c [4], input logic has);
    clip_result_t e;
    e.x = (has && dims > 0) ? c[0] : '0;
    e.y = (has && dims > 1) ? c[1] : '0;
    e.z = (has && dims > 2) ? c[2] : '0;
    e.m = (has && dims > 3) ? c[3] : '0;
    e.has_point = has;
    e.part_end  = !has;
    e.run_last  = 1'b0;
    staged.push_back(e);
  endfunction

  function automatic void close_open_part();
    coord_t zero4 [4];
    if (!part_live) return;
    if (staged.size() > 0) begin
      staged[staged.size()-1].part_end = 1'b1;
    end else begin
      zero4 = '{default: '0};
      stage_point(zero4, 1'b0);
    end
    part_live = 1'b0;
  endfunction

  function automatic void predict_vertex(input coord_t vin [4], input logic last_vtx);
    coord_t lo, hi, key, q, r [4];
    logic first;
    lo = band_a < band_b ? band_a : band_b;
    hi = band_a < band_b ? band_b : band_a;
    first = line_fresh;
    q = last_key;
    key = vin[axis_sel];
    staged.delete();
    if (axis_sel >= dims) begin
      track = IM_NONE;
      part_live = 1'b0;
    end else begin
      if (key >= lo && key <= hi) begin
        if (track == IM_NONE && !first && ((key > lo && key < hi) ||
            (key == lo && q > hi) || (key == hi && q < lo))) begin
          interpolate(last_pt, vin, q > hi ? hi : lo, r);
          stage_point(r, 1'b1);
        end
        stage_point(vin, 1'b1);
        track = (key == lo || key == hi) ? IM_BOUND : IM_INNER;
        part_live = 1'b1;
      end else begin
        if (track == IM_INNER) begin
          interpolate(last_pt, vin, key > hi ? hi : lo, r);
          stage_point(r, 1'b1);
        end else if (track == IM_BOUND) begin
          if (lo != hi && ((q == lo && key > lo) || (q == hi && key < hi))) begin
            interpolate(last_pt, vin, key > hi ? hi : lo, r);
            stage_point(r, 1'b1);
          end
        end else if (!first && ((q < lo && key > hi) || (q > hi && key < lo))) begin
          // jump across the band: both bounds, measured from the current vertex
          interpolate(vin, last_pt, q < lo ? lo : hi, r);
          stage_point(r, 1'b1);
          interpolate(vin, last_pt, q < lo ? hi : lo, r);
          stage_point(r, 1'b1);
          part_live = 1'b1;
        end
        close_open_part();
        track = IM_NONE;
      end
      if (last_vtx) begin
        close_open_part();
        track = IM_NONE;
      end
    end
    last_pt = vin;
    last_key = key;
    line_fresh = last_vtx;
    if (staged.size() > 0) staged[staged.size()-1].run_last = 1'b1;
    foreach (staged[i]) results_due.push_back(staged[i]);
  endfunction

  always @(posedge clk) begin
    clip_result_t got, want;
    coord_t vin [4];
    if (!rst_n) begin
      band_a <= '0;
      band_b <= '0;
      axis_sel <= '0;
      dims <= 3'd4;
      last_pt = '{default: '0};
      last_key = '0;
      track = IM_NONE;
      part_live = 1'b0;
      line_fresh = 1'b1;
      results_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CLIP_LOW:  band_a <= cfg_data;
          REG_CLIP_HIGH: band_b <= cfg_data;
          REG_ORD_SEL:   axis_sel <= cfg_data[1:0];
          REG_DIMS:      dims <= cfg_data[2:0];
          default:       ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.ox, out_chan.oy, out_chan.oz, out_chan.om,
                out_chan.has_point, out_chan.part_end, out_chan.run_last};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        vin = '{in_chan.vx, in_chan.vy, in_chan.vz, in_chan.vm};
        predict_vertex(vin, in_chan.line_end);
      end
    end
  end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Top of the clipper testbench: clock, reset, register writes, vertex stimulus
// and random output stalls. Depends on porc_pkg, the interfaces and porc_checker.
module tb import porc_pkg::*;;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycles = 0;

  porc_in_if  in_chan ();
  porc_out_if out_chan ();

  polyline_ordinate_range_clipper_top uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  porc_checker chk (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  coord_t cur_lo, cur_hi;
  logic [1:0] cur_axis;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.vx = '0; in_chan.vy = '0; in_chan.vz = '0; in_chan.vm = '0;
    in_chan.line_end = 1'b0;
    out_chan.ready = 1'b0;
  end

  // Random stalls on the result side, with quiet stretches.
  always @(negedge clk) begin
    int gap;
    if (rst_n && !(out_chan.valid && out_chan.ready)) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (out_chan.ready == 1'b0 && gap > 0) repeat (gap) @(negedge clk);
      out_chan.ready <= ($urandom_range(0, 3) != 0);
    end else if (rst_n) begin
      out_chan.ready <= ($urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_band(input coord_t a, input coord_t b, input logic [1:0] ax,
                          input logic [2:0] nd);
    in_chan.valid <= 1'b0;
    drain();
    write_reg(REG_CLIP_LOW, a);
    write_reg(REG_CLIP_HIGH, b);
    write_reg(REG_ORD_SEL, 32'(ax));
    write_reg(REG_DIMS, 32'(nd));
    cur_lo = a < b ? a : b;
    cur_hi = a < b ? b : a;
    cur_axis = ax;
  endtask

  // Valid stays high after a transfer until the next vertex or a pause drops it.
  task automatic send_vertex(input coord_t x, y, z, m, input logic last_vtx,
                             input bit no_gap = 1'b0);
    int gap;
    gap = (!no_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.vx <= x; in_chan.vy <= y; in_chan.vz <= z; in_chan.vm <= m;
    in_chan.line_end <= last_vtx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Key value for the selected axis: below, on a bound, inside, or above the band, or fully random.
  function automatic coord_t pick_key();
    case ($urandom_range(0, 6))
      0: return cur_lo - coord_t'($urandom_range(1, 1 << 20));
      1: return cur_lo;
      2: return cur_hi;
      3: return cur_hi + coord_t'($urandom_range(1, 1 << 20));
      4: return coord_t'($urandom);
      default: return cur_lo + coord_t'(($urandom % (64'(cur_hi) - 64'(cur_lo) + 1)));
    endcase
  endfunction

  task automatic send_random(input logic last_vtx);
    coord_t c [4];
    foreach (c[i]) c[i] = coord_t'($urandom);
    if ($urandom_range(0, 9) != 0) c[cur_axis] = pick_key();
    send_vertex(c[0], c[1], c[2], c[3], last_vtx);
  endtask

  initial begin
    int left;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: bounds reversed, enter/leave, jump over, bound hits.
    set_band(32'sh0005_0000, 32'sh0001_0000, 2'd0, 3'd4);
    send_vertex(32'sh0000_0000, 1, 2, 3, 1'b0);
    send_vertex(32'sh0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, -1, 1'b0);
    send_vertex(32'sh0009_0000, 32'h8000_0000, 32'h7FFF_FFFF, 5, 1'b0);
    send_vertex(-32'sh0009_0000, 7, 8, 9, 1'b0);
    send_vertex(32'sh0001_0000, 1, 1, 1, 1'b0);
    send_vertex(32'sh0005_0000, 2, 2, 2, 1'b0);
    send_vertex(32'sh0006_0000, 3, 3, 3, 1'b0);
    send_vertex(32'sh0005_0000, 3, 3, 3, 1'b0);
    send_vertex(32'sh0002_0000, 4, 4, 4, 1'b1);
    // Degenerate band, leave from the bound.
    set_band(32'sh0002_0000, 32'sh0002_0000, 2'd1, 3'd3);
    send_vertex(0, 32'sh0002_0000, 5, 6, 1'b0);
    send_vertex(0, 32'sh0004_0000, 5, 6, 1'b0);
    send_vertex(0, 32'sh0000_0000, 5, 6, 1'b0);
    send_vertex(0, 32'sh0002_0000, 5, 6, 1'b1);
    // Extremes of the range and a bad ordinate.
    set_band(32'h8000_0000, 32'h7FFF_FFFF, 2'd3, 3'd4);
    send_vertex(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1);
    set_band(32'sh0000_0000, 32'sh0001_0000, 2'd3, 3'd2);
    send_vertex(1, 2, 3, 4, 1'b0);
    send_vertex(1, 2, 3, 4, 1'b1);
    set_band(32'sh0000_0000, 32'sh0001_0000, 2'd2, 3'd7);
    send_vertex(0, 0, 32'sh0000_8000, 0, 1'b0);
    send_vertex(0, 0, 32'sh0000_8000, 0, 1'b1);
    set_band(32'sh0000_0000, 32'sh0001_0000, 2'd0, 3'd0);
    send_vertex(0, 0, 0, 0, 1'b1);

    // Random phases: short polylines over assorted bands and axes.
    for (int phase = 0; phase < 12; phase++) begin
      logic [1:0] ax;
      logic [2:0] nd;
      ax = 2'($urandom_range(0, 3));
      nd = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(ax + 1, 4));
      if (phase == 0) set_band(32'h8000_0000, 32'h7FFF_FFFF, ax, nd);
      else set_band(coord_t'($urandom), coord_t'($urandom) >>> $urandom_range(0, 12),
                    ax, nd);
      left = 150;
      while (left > 0) begin
        int len;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len && left > 0; k++, left--) begin
          send_random(k == len - 1 || left == 1);
          // Change the axis mid-line now and then once traffic has settled.
          if (k == 2 && $urandom_range(0, 40) == 0) begin
            in_chan.valid <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (100) @(negedge clk);
            cur_axis = 2'($urandom_range(0, 3));
            write_reg(REG_ORD_SEL, 32'(cur_axis));
          end
        end
      end
    end
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/porc_pkg.sv
rtl/core/porc_in_if.sv
rtl/core/porc_out_if.sv
rtl/core/polyline_ordinate_range_clipper_top.sv
dv/porc_tb_if.sv
dv/porc_checker.sv
dv/tb.sv
